@@ src/qss_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants and types for the quintic spline sampler.
package qss_pkg;

  localparam int FRAC      = 24;  // fraction bits of time, powers and coefficients
  localparam int PW        = 63;  // width of the time powers, saturate at 2^63-1
  localparam int NCOEF     = 6;
  localparam int MUL_CHUNK = 32;  // partial product operand width
  localparam int MUL_LAT   = 3;   // register stages in the chunked multiplier
  localparam int MULT_BITS = 5;   // largest derivative factor is 20

  localparam logic [2:0] REG_COEF0    = 3'd0;
  localparam logic [2:0] REG_COEF1    = 3'd1;
  localparam logic [2:0] REG_COEF2    = 3'd2;
  localparam logic [2:0] REG_COEF3    = 3'd3;
  localparam logic [2:0] REG_COEF4    = 3'd4;
  localparam logic [2:0] REG_COEF5    = 3'd5;
  localparam logic [2:0] REG_DURATION = 3'd6;

  typedef enum logic [1:0] {
    CLAMP_NONE   = 2'd0,
    CLAMP_BEFORE = 2'd1,
    CLAMP_AFTER  = 2'd2
  } clamp_t;

  // Terms that need a multiplier: position 0..4, velocity 5..8, acceleration 9..11.
  localparam int NT = 12;
  localparam int TERM_COEF [NT] = '{1, 2, 3, 4, 5, 2, 3, 4, 5, 3, 4, 5};
  localparam int TERM_POW  [NT] = '{1, 2, 3, 4, 5, 1, 2, 3, 4, 1, 2, 3};
  localparam int TERM_MULT [NT] = '{1, 1, 1, 1, 1, 2, 3, 4, 5, 6, 12, 20};

endpackage

@@ src/qss_mul.sv @@
`timescale 1ns / 1ps
// Three-stage unsigned multiplier built from 32x32 partial products.
module qss_mul #(
  parameter int WA = 48,
  parameter int WB = 63
) (
  input  logic               clk,
  input  logic [2:0]         en,
  input  logic [WA-1:0]      a,
  input  logic [WB-1:0]      b,
  output logic [WA+WB-1:0]   p
);

  localparam int CH  = qss_pkg::MUL_CHUNK;
  localparam int NA  = (WA + CH - 1) / CH;
  localparam int NB  = (WB + CH - 1) / CH;
  localparam int RW  = CH * (NB + 1);
  localparam int XW  = CH * (NA + NB);
  localparam int PRW = WA + WB;

  logic [CH*NA-1:0] a_x;
  logic [CH*NB-1:0] b_x;
  logic [2*CH-1:0]  pp_r   [NA][NB];
  logic [RW-1:0]    row_nxt [NA];
  logic [RW-1:0]    row_r   [NA];
  logic [XW-1:0]    sum_nxt;
  logic [PRW-1:0]   p_r;

  assign a_x = (CH*NA)'(a);
  assign b_x = (CH*NB)'(b);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= (2*CH)'(a_x[i*CH +: CH]) * (2*CH)'(b_x[j*CH +: CH]);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (RW'(pp_r[i][j]) << (CH * j));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NA; i++) begin
        row_r[i] <= row_nxt[i];
      end
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      sum_nxt = sum_nxt + (XW'(row_r[i]) << (CH * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p_r <= sum_nxt[PRW-1:0];
    end
  end

  assign p = p_r;

endmodule

@@ src/quintic_spline_sampler_unit.sv @@
`timescale 1ns / 1ps
// Top level of the quintic spline sampler: clamp, power chain, terms and sums.
// Latency: a result becomes valid after passing the clamp stage, then the chain of four
// time-power multipliers, each a three-stage chunked multiplier plus a saturation stage,
// followed by the term multiplier, round, scale, sign, adder and output stages.
// Throughput: one transaction per cycle while out_tready is high, when every stage takes a new
// transaction each cycle; a stall holds only full stages, so bubbles are squeezed out before in_tready drops.
// Reset clears all valid bits and the coefficient and duration registers to zero.
module quintic_spline_sampler_unit #(
  parameter int COEF_WIDTH = 48,
  parameter int TIME_WIDTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [((COEF_WIDTH > TIME_WIDTH - 1) ? COEF_WIDTH : TIME_WIDTH - 1) - 1:0] cfg_wdata,
  input  logic in_tvalid,
  output logic in_tready,
  // sample_time
  input  logic [((TIME_WIDTH + 7) / 8) * 8 - 1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // position, velocity, acceleration
  output logic [((3 * COEF_WIDTH + 7) / 8) * 8 - 1:0] out_tdata,
  // clamp_code
  output logic [1:0] out_tuser
);

  localparam int CW   = COEF_WIDTH;
  localparam int TV   = TIME_WIDTH - 1;
  localparam int PW   = qss_pkg::PW;
  localparam int FRAC = qss_pkg::FRAC;
  localparam int NT   = qss_pkg::NT;
  localparam int OTW  = ((3 * COEF_WIDTH + 7) / 8) * 8;
  localparam int PRW  = CW + PW;
  localparam int SW   = PRW - FRAC;
  localparam int SCW  = SW + qss_pkg::MULT_BITS;
  localparam int ACCW = SCW + 4;
  localparam int PPW  = PW + TV;
  localparam int PPX  = (PPW > PW + FRAC) ? PPW : PW + FRAC;

  localparam int POW_LAT = qss_pkg::MUL_LAT + 1;
  localparam int TS      = POW_LAT * (qss_pkg::NCOEF - 2);
  localparam int S_ROUND = TS + qss_pkg::MUL_LAT + 1;
  localparam int S_SCALE = S_ROUND + 1;
  localparam int S_SIGN  = S_SCALE + 1;
  localparam int S_ADD1  = S_SIGN + 1;
  localparam int S_ADD2  = S_ADD1 + 1;
  localparam int S_ADD3  = S_ADD2 + 1;
  localparam int S_OUT   = S_ADD3 + 1;
  localparam int NS      = S_OUT + 1;

  // configuration
  logic [CW-1:0] coef_r [qss_pkg::NCOEF];
  logic [CW-1:0] mag_r  [1:qss_pkg::NCOEF-1];
  logic [TV-1:0] dur_r;
  logic [CW-1:0] cfg_coef;
  logic [CW-1:0] cfg_mag;

  assign cfg_coef = cfg_wdata[CW-1:0];
  assign cfg_mag  = cfg_coef[CW-1] ? (~cfg_coef + 1'b1) : cfg_coef;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < qss_pkg::NCOEF; i++) begin
        coef_r[i] <= '0;
      end
      for (int i = 1; i < qss_pkg::NCOEF; i++) begin
        mag_r[i] <= '0;
      end
      dur_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        qss_pkg::REG_COEF0: coef_r[0] <= cfg_coef;
        qss_pkg::REG_COEF1, qss_pkg::REG_COEF2, qss_pkg::REG_COEF3,
        qss_pkg::REG_COEF4, qss_pkg::REG_COEF5: begin
          coef_r[cfg_index] <= cfg_coef;
          mag_r[cfg_index]  <= cfg_mag;
        end
        qss_pkg::REG_DURATION: dur_r <= cfg_wdata[TV-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int s = NS - 2; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_tvalid;
      for (int s = 1; s < NS; s++) begin
        if (en[s]) v_r[s] <= v_r[s-1];
      end
    end
  end

  assign in_tready = en[0];

  // clamp stage
  logic [TIME_WIDTH-1:0] sample_time;
  logic [TV-1:0]         t_nxt;
  qss_pkg::clamp_t       code_nxt;
  logic [TV-1:0]         t_r    [0:TS];
  qss_pkg::clamp_t       code_r [0:S_OUT];

  assign sample_time = in_tdata[TIME_WIDTH-1:0];

  always_comb begin
    if (sample_time[TIME_WIDTH-1]) begin
      t_nxt    = '0;
      code_nxt = qss_pkg::CLAMP_BEFORE;
    end else if (sample_time[TV-1:0] > dur_r) begin
      t_nxt    = dur_r;
      code_nxt = qss_pkg::CLAMP_AFTER;
    end else begin
      t_nxt    = sample_time[TV-1:0];
      code_nxt = qss_pkg::CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t_r[0]    <= t_nxt;
      code_r[0] <= code_nxt;
    end
    for (int s = 1; s <= TS; s++) begin
      if (en[s]) t_r[s] <= t_r[s-1];
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) code_r[s] <= code_r[s-1];
    end
  end

  // time powers P2..P5, each delayed to the term stage
  logic [PW-1:0] pw_new [1:qss_pkg::NCOEF-2];
  logic [PW-1:0] pw_end [1:qss_pkg::NCOEF-1];

  assign pw_new[1] = PW'(t_r[0]);
  assign pw_end[1] = PW'(t_r[TS]);

  for (genvar k = 2; k < qss_pkg::NCOEF; k++) begin : g_pow
    localparam int SI = POW_LAT * (k - 2);
    localparam int SO = SI + POW_LAT;
    logic [PPW-1:0] prod;
    logic [PPX-1:0] prod_x;
    logic [PW-1:0]  pw_nxt;
    logic [PW-1:0]  dly_r [SO:TS];

    qss_mul #(.WA(PW), .WB(TV)) u_mul (
      .clk,
      .en (en[SI+1 +: qss_pkg::MUL_LAT]),
      .a  (pw_new[k-1]),
      .b  (t_r[SI]),
      .p  (prod)
    );

    assign prod_x = PPX'(prod);
    assign pw_nxt = ((prod_x >> (PW + FRAC)) != '0) ? {PW{1'b1}}
                                                    : prod_x[PW+FRAC-1:FRAC];

    always_ff @(posedge clk) begin
      if (en[SO]) dly_r[SO] <= pw_nxt;
      for (int s = SO + 1; s <= TS; s++) begin
        if (en[s]) dly_r[s] <= dly_r[s-1];
      end
    end

    if (k < qss_pkg::NCOEF - 1) begin : g_fwd
      assign pw_new[k] = dly_r[SO];
    end
    assign pw_end[k] = dly_r[TS];
  end

  // coefficient times power terms, floored, scaled by derivative factor, signed
  logic [ACCW-1:0] tval [NT];

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam int KC = qss_pkg::TERM_COEF[i];
    localparam int KP = qss_pkg::TERM_POW[i];
    localparam int KM = qss_pkg::TERM_MULT[i];
    logic [PRW-1:0]  prod;
    logic            neg;
    logic [SW-1:0]   mag_s_r;
    logic [SCW-1:0]  scl_r;
    logic [ACCW-1:0] val_r;

    assign neg = coef_r[KC][CW-1];

    qss_mul #(.WA(CW), .WB(PW)) u_mul (
      .clk,
      .en (en[TS+1 +: qss_pkg::MUL_LAT]),
      .a  (mag_r[KC]),
      .b  (pw_end[KP]),
      .p  (prod)
    );

    always_ff @(posedge clk) begin
      if (en[S_ROUND]) begin
        // round the magnitude up for negative terms: floor toward minus infinity
        mag_s_r <= SW'(prod >> FRAC) + SW'(neg && (prod[FRAC-1:0] != '0));
      end
      if (en[S_SCALE]) scl_r <= SCW'(mag_s_r) * SCW'(KM);
      if (en[S_SIGN])  val_r <= neg ? (~ACCW'(scl_r) + 1'b1) : ACCW'(scl_r);
    end

    assign tval[i] = val_r;
  end

  // terms with P0 = 1.0 are the coefficients themselves, with coefficient 2 doubled for acceleration
  logic [ACCW-1:0] c0_ext, c1_ext, c2_dbl;

  assign c0_ext = {{(ACCW - CW){coef_r[0][CW-1]}}, coef_r[0]};
  assign c1_ext = {{(ACCW - CW){coef_r[1][CW-1]}}, coef_r[1]};
  assign c2_dbl = {{(ACCW - CW - 1){coef_r[2][CW-1]}}, coef_r[2], 1'b0};

  // adder tree
  logic [ACCW-1:0] pos1_r [3];
  logic [ACCW-1:0] vel1_r [3];
  logic [ACCW-1:0] acc1_r [2];
  logic [ACCW-1:0] pos2_r [2];
  logic [ACCW-1:0] vel2_r [2];
  logic [ACCW-1:0] acc2_r;
  logic [ACCW-1:0] pos3_r, vel3_r, acc3_r;

  always_ff @(posedge clk) begin
    if (en[S_ADD1]) begin
      pos1_r[0] <= c0_ext + tval[0];
      pos1_r[1] <= tval[1] + tval[2];
      pos1_r[2] <= tval[3] + tval[4];
      vel1_r[0] <= c1_ext + tval[5];
      vel1_r[1] <= tval[6] + tval[7];
      vel1_r[2] <= tval[8];
      acc1_r[0] <= c2_dbl + tval[9];
      acc1_r[1] <= tval[10] + tval[11];
    end
    if (en[S_ADD2]) begin
      pos2_r[0] <= pos1_r[0] + pos1_r[1];
      pos2_r[1] <= pos1_r[2];
      vel2_r[0] <= vel1_r[0] + vel1_r[1];
      vel2_r[1] <= vel1_r[2];
      acc2_r    <= acc1_r[0] + acc1_r[1];
    end
    if (en[S_ADD3]) begin
      pos3_r <= pos2_r[0] + pos2_r[1];
      vel3_r <= vel2_r[0] + vel2_r[1];
      acc3_r <= acc2_r;
    end
  end

  function automatic logic [COEF_WIDTH-1:0] sat_f(input logic [ACCW-1:0] v);
    logic [ACCW-COEF_WIDTH:0] top_bits;
    top_bits = v[ACCW-1:COEF_WIDTH-1];
    if (top_bits == '0 || top_bits == '1) begin
      sat_f = v[COEF_WIDTH-1:0];
    end else if (v[ACCW-1]) begin
      sat_f = {1'b1, {(COEF_WIDTH - 1){1'b0}}};
    end else begin
      sat_f = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
    end
  endfunction

  // output register
  logic [CW-1:0] position_r, velocity_r, acceleration_r;
  logic          inside_seg;

  assign inside_seg = (code_r[S_ADD3] == qss_pkg::CLAMP_NONE);

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      position_r     <= sat_f(pos3_r);
      velocity_r     <= inside_seg ? sat_f(vel3_r) : '0;
      acceleration_r <= inside_seg ? sat_f(acc3_r) : '0;
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = OTW'({acceleration_r, velocity_r, position_r});
  assign out_tuser  = code_r[S_OUT];

  a_clamped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (code_r[S_OUT] != qss_pkg::CLAMP_NONE)
      |-> (velocity_r == '0) && (acceleration_r == '0))
    else $error("clamped transaction with nonzero velocity or acceleration");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (&v_r))
    else $error("input stalled while the pipeline has a bubble");

  a_inside_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && (code_r[0] == qss_pkg::CLAMP_NONE) |-> (t_r[0] <= dur_r))
    else $error("unclamped time beyond segment duration");

  a_before_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && (code_r[0] == qss_pkg::CLAMP_BEFORE) |-> (t_r[0] == '0))
    else $error("time before start not forced to zero");

endmodule
